### design/cte_pkg.sv
package cte_pkg;

  localparam int unsigned TAG_LIMIT   = 16;
  localparam int unsigned TAG_MAX_DEF = 16;
  localparam int unsigned CNT_W       = $clog2(TAG_LIMIT + 4);
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_LEN = 2'd0,
    CFG_TAG_LO  = 2'd1,
    CFG_TAG_HI  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LT    = 2'd1,
    PH_MATCH = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       text_end;
  } out_t;

  typedef struct packed {
    logic [4:0]            tag_len;
    logic [15:0][7:0]      tag;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             text_last;
  } burst_ctl_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UA && c <= CH_UZ) begin
      r = c + CASE_BIT;
    end
    return r;
  endfunction

endpackage

### design/cte_skid.sv
module cte_skid (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cte_pkg::in_t  in_data_i,
  output logic          head_valid_o,
  output cte_pkg::in_t  head_o,
  input  logic          pop_i
);

  cte_pkg::in_t mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         push, pop;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rp_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

endmodule

### design/cte_cfg.sv
module cte_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cte_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output cte_pkg::cfg_t                  cfg_o
);

  cte_pkg::cfg_t cfg_q;

  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cte_pkg::CFG_TAG_LEN: cfg_q.tag_len    <= cfg_data_i[4:0];
        cte_pkg::CFG_TAG_LO:  cfg_q.tag[7:0]   <= cfg_data_i;
        cte_pkg::CFG_TAG_HI:  cfg_q.tag[15:8]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### design/cte_matcher.sv
module cte_matcher #(
  parameter int unsigned TagMax = cte_pkg::TAG_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cte_pkg::cfg_t                cfg_i,
  input  logic                         head_valid_i,
  input  cte_pkg::in_t                 head_i,
  input  logic                         ready_i,
  output logic                         take_o,
  output logic [TagMax+2:0][7:0]       bytes_o,
  output cte_pkg::burst_ctl_t          ctl_o
);

  localparam int unsigned MW = $clog2(TagMax + 1);
  localparam int unsigned HW = (TagMax > 1) ? $clog2(TagMax) : 1;
  localparam int unsigned BN = TagMax + 3;

  cte_pkg::phase_e phase_q, phase_d;
  logic [MW-1:0]   mc_q, mc_d;
  logic [7:0]      held_q  [TagMax];
  logic [7:0]      held_nx [TagMax];

  logic [MW-1:0]   len, n, mc_inc;
  logic [7:0]      b, tag_b, lead1;
  logic            last, is_lt, is_sl, match_ok, grp_idle, held_wr;
  logic            lt, bs, sl, tail;
  logic [1:0]      lead_n;

  assign take_o = head_valid_i && ready_i;
  assign b      = head_i.in_byte;
  assign last   = head_i.in_last;
  assign is_lt  = (b == cte_pkg::CH_LT);
  assign is_sl  = (b == cte_pkg::CH_SLASH);
  assign mc_inc = mc_q + MW'(1);
  assign tag_b  = cfg_i.tag[4'(mc_q)];

  always_comb begin
    if (cfg_i.tag_len > 5'(TagMax)) begin
      len = MW'(TagMax);
    end else begin
      len = MW'(cfg_i.tag_len);
    end
  end

  assign match_ok = (mc_q < len) && (cte_pkg::fold(b) == cte_pkg::fold(tag_b));

  always_comb begin
    lt       = 1'b0;
    bs       = 1'b0;
    sl       = 1'b0;
    n        = '0;
    tail     = 1'b0;
    phase_d  = phase_q;
    mc_d     = mc_q;
    held_wr  = 1'b0;
    grp_idle = 1'b0;
    if (len == '0) begin
      grp_idle = 1'b1;
    end else begin
      unique case (phase_q)
        cte_pkg::PH_LT: begin
          if (is_sl) begin
            phase_d = cte_pkg::PH_MATCH;
            mc_d    = '0;
            lt      = last;
            sl      = last;
          end else if (is_lt) begin
            lt   = 1'b1;
            tail = last;
          end else begin
            lt      = 1'b1;
            tail    = 1'b1;
            phase_d = cte_pkg::PH_IDLE;
          end
        end
        cte_pkg::PH_MATCH: begin
          if (match_ok) begin
            held_wr = 1'b1;
            if (mc_inc == len) begin
              lt      = 1'b1;
              bs      = 1'b1;
              sl      = 1'b1;
              n       = len;
              phase_d = cte_pkg::PH_IDLE;
              mc_d    = '0;
            end else begin
              mc_d = mc_inc;
              lt   = last;
              sl   = last;
              n    = last ? mc_inc : '0;
            end
          end else begin
            grp_idle = 1'b1;
          end
        end
        default: grp_idle = 1'b1;
      endcase
    end
    // flush what is pending, then treat the byte as if idle
    if (grp_idle) begin
      lt   = (phase_q != cte_pkg::PH_IDLE);
      sl   = (phase_q == cte_pkg::PH_MATCH);
      n    = (phase_q == cte_pkg::PH_MATCH) ? mc_q : '0;
      mc_d = '0;
      if (is_lt && len != '0) begin
        phase_d = cte_pkg::PH_LT;
        tail    = last;
      end else begin
        phase_d = cte_pkg::PH_IDLE;
        tail    = 1'b1;
      end
    end
    if (last) begin
      phase_d = cte_pkg::PH_IDLE;
      mc_d    = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < TagMax; i++) begin
      held_nx[i] = (held_wr && mc_q[HW-1:0] == HW'(i)) ? b : held_q[i];
    end
  end

  assign lead_n = {1'b0, lt} + {1'b0, bs} + {1'b0, sl};
  assign lead1  = bs ? cte_pkg::CH_BSLASH : cte_pkg::CH_SLASH;

  always_comb begin
    for (int k = 0; k < BN; k++) begin
      if (k < int'(lead_n)) begin
        if (k == 0) begin
          bytes_o[k] = cte_pkg::CH_LT;
        end else if (k == 1) begin
          bytes_o[k] = lead1;
        end else begin
          bytes_o[k] = cte_pkg::CH_SLASH;
        end
      end else if (k < int'(lead_n) + int'(n)) begin
        bytes_o[k] = held_nx[HW'(k - int'(lead_n))];
      end else begin
        bytes_o[k] = b;
      end
    end
  end

  assign ctl_o.count     = cte_pkg::CNT_W'(lead_n) + cte_pkg::CNT_W'(n)
                         + cte_pkg::CNT_W'(tail);
  assign ctl_o.text_last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cte_pkg::PH_IDLE;
      mc_q    <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      mc_q    <= mc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && held_wr) begin
      held_q[mc_q[HW-1:0]] <= b;
    end
  end

endmodule

### design/cte_emitter.sv
module cte_emitter #(
  parameter int unsigned TagMax = cte_pkg::TAG_MAX_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    take_i,
  input  logic [TagMax+2:0][7:0]  bytes_i,
  input  cte_pkg::burst_ctl_t     ctl_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output cte_pkg::out_t           out_data_o
);

  localparam int unsigned BN = TagMax + 3;
  localparam int unsigned PW = $clog2(BN);

  logic [TagMax+2:0][7:0]        bytes_q;
  logic [cte_pkg::CNT_W-1:0]     cnt_q, ptr_q, ptr_inc;
  logic                          last_q, out_acc, final_pos;

  assign ptr_inc     = ptr_q + cte_pkg::CNT_W'(1);
  assign out_valid_o = (ptr_q != cnt_q);
  assign final_pos   = (ptr_inc == cnt_q);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign ready_o     = !out_valid_o || (final_pos && out_acc);

  assign out_data_o.out_byte = bytes_q[ptr_q[PW-1:0]];
  assign out_data_o.run_end  = final_pos;
  assign out_data_o.text_end = final_pos && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ptr_q  <= '0;
      last_q <= 1'b0;
    end else if (take_i) begin
      cnt_q  <= ctl_i.count;
      ptr_q  <= '0;
      last_q <= ctl_i.text_last;
    end else if (out_acc) begin
      ptr_q <= ptr_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      bytes_q <= bytes_i;
    end
  end

endmodule

### design/closing_tag_escaper.sv
// Byte stream filter that writes "</tag" as "<\/tag" for the configured tag
// (case folded on A-Z, prefix compare). An item is one text byte. Bytes that
// yield zero or one result each let plain text stream at one byte per cycle
// while the output is not stalled; a byte that releases held bytes yields up
// to TagMax + 3 results, which leave the output register one at a time, and
// the input backs up meanwhile. From input accept to the first result a byte
// passes a two-entry input buffer, then the match logic loading the result
// burst register. The user must see that tag registers are written only
// while the block is idle; the block itself does not enforce this.
module closing_tag_escaper #(
  parameter int unsigned TagMax = cte_pkg::TAG_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  cte_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output cte_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [cte_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cte_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cte_pkg::cfg_t          cfg;
  cte_pkg::in_t           head;
  cte_pkg::burst_ctl_t    ctl;
  logic                   head_valid, take, ready;
  logic [TagMax+2:0][7:0] bytes;

  cte_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cte_skid u_skid (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (take)
  );

  cte_matcher #(.TagMax(TagMax)) u_matcher (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .ready_i      (ready),
    .take_o       (take),
    .bytes_o      (bytes),
    .ctl_o        (ctl)
  );

  cte_emitter #(.TagMax(TagMax)) u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .bytes_i     (bytes),
    .ctl_i       (ctl),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### design/cte_checker.sv
module cte_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input cte_pkg::out_t                  out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.run_end |=> out_valid_o)
    else $error("result run broken before its end");

  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall rose without an accepted item");

endmodule

bind closing_tag_escaper cte_checker u_cte_checker (.*);

### sim/closing_tag_escaper_tb.sv
module closing_tag_escaper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TagMax         = cte_pkg::TAG_MAX_DEF;
  localparam int unsigned ClkPeriod      = 10;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned RandomItems    = 200;
  localparam int unsigned WatchdogLimit  = 2000;

  typedef struct {
    bit                             is_cfg;
    cte_pkg::cfg_idx_e              idx;
    logic [cte_pkg::CFG_DATA_W-1:0] data;
    cte_pkg::in_t                   item;
    bit                             typed;
    cte_pkg::out_t                  want;
  } dir_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  cte_pkg::in_t                   in_data_i;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  cte_pkg::out_t                  out_data_o;
  logic                           cfg_we_i;
  logic [cte_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [cte_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // predictor state
  cte_pkg::cfg_t   tag_cfg;
  cte_pkg::phase_e cur_phase;
  int unsigned     match_cnt;
  logic [7:0]      held_bytes [16];
  cte_pkg::out_t   burst_q[$];
  cte_pkg::out_t   escaped_q[$];

  dir_row_t    dir_rows[$];
  int unsigned n_sent;
  int unsigned n_fail;
  int unsigned idle_cycles;
  int unsigned rx_left;
  bit          calm;

  closing_tag_escaper #(
    .TagMax(TagMax)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (c >= cte_pkg::CH_UA && c <= cte_pkg::CH_UZ) begin
      return c + cte_pkg::CASE_BIT;
    end
    return c;
  endfunction

  function automatic void put(input logic [7:0] b);
    cte_pkg::out_t r;
    r.out_byte = b;
    r.run_end  = 1'b0;
    r.text_end = 1'b0;
    burst_q.insert(burst_q.size(), r);
  endfunction

  function automatic void flush_held();
    if (cur_phase == cte_pkg::PH_LT) begin
      put(cte_pkg::CH_LT);
    end else if (cur_phase == cte_pkg::PH_MATCH) begin
      put(cte_pkg::CH_LT);
      put(cte_pkg::CH_SLASH);
      for (int i = 0; i < match_cnt; i++) begin
        put(held_bytes[i]);
      end
    end
    cur_phase = cte_pkg::PH_IDLE;
    match_cnt = 0;
  endfunction

  function automatic void take_fresh(input logic [7:0] b, input int unsigned len);
    if (b == cte_pkg::CH_LT && len > 0) begin
      cur_phase = cte_pkg::PH_LT;
    end else begin
      put(b);
      cur_phase = cte_pkg::PH_IDLE;
    end
    match_cnt = 0;
  endfunction

  function automatic void escape_byte(input cte_pkg::in_t it);
    int unsigned len;
    logic [7:0]  b;
    burst_q.delete();
    b   = it.in_byte;
    len = (tag_cfg.tag_len > TagMax) ? TagMax : tag_cfg.tag_len;
    if (len == 0) begin
      flush_held();
      take_fresh(b, len);
    end else if (cur_phase == cte_pkg::PH_LT) begin
      if (b == cte_pkg::CH_SLASH) begin
        cur_phase = cte_pkg::PH_MATCH;
        match_cnt = 0;
      end else if (b == cte_pkg::CH_LT) begin
        put(cte_pkg::CH_LT);
      end else begin
        put(cte_pkg::CH_LT);
        put(b);
        cur_phase = cte_pkg::PH_IDLE;
      end
    end else if (cur_phase == cte_pkg::PH_MATCH) begin
      if (match_cnt >= len) begin
        flush_held();
        take_fresh(b, len);
      end else if (to_lower(b) == to_lower(tag_cfg.tag[match_cnt])) begin
        held_bytes[match_cnt] = b;
        match_cnt++;
        if (match_cnt == len) begin
          put(cte_pkg::CH_LT);
          put(cte_pkg::CH_BSLASH);
          put(cte_pkg::CH_SLASH);
          for (int i = 0; i < match_cnt; i++) begin
            put(held_bytes[i]);
          end
          cur_phase = cte_pkg::PH_IDLE;
          match_cnt = 0;
        end
      end else begin
        flush_held();
        take_fresh(b, len);
      end
    end else begin
      take_fresh(b, len);
    end
    if (it.in_last) begin
      flush_held();
    end
    if (burst_q.size() > 0) begin
      burst_q[burst_q.size() - 1].run_end = 1'b1;
      if (it.in_last) begin
        burst_q[burst_q.size() - 1].text_end = 1'b1;
      end
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_row(input bit is_cfg, input cte_pkg::cfg_idx_e idx,
                                  input logic [cte_pkg::CFG_DATA_W-1:0] data,
                                  input logic [7:0] b, input logic last,
                                  input bit typed, input cte_pkg::out_t want);
    dir_row_t row;
    row.is_cfg       = is_cfg;
    row.idx          = idx;
    row.data         = data;
    row.item.in_byte = b;
    row.item.in_last = last;
    row.typed        = typed;
    row.want         = want;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  function automatic void add_cfg(input cte_pkg::cfg_idx_e idx,
                                  input logic [cte_pkg::CFG_DATA_W-1:0] data);
    add_row(1'b1, idx, data, 8'h00, 1'b0, 1'b0, '0);
  endfunction

  function automatic void add_typed(input logic [7:0] b, input logic last,
                                    input cte_pkg::out_t want);
    add_row(1'b0, cte_pkg::CFG_TAG_LEN, '0, b, last, 1'b1, want);
  endfunction

  function automatic void add_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      add_row(1'b0, cte_pkg::CFG_TAG_LEN, '0, s[i], last && (i == s.len() - 1), 1'b0, '0);
    end
  endfunction

  task automatic send_text_byte(input cte_pkg::in_t it, input bit typed,
                                input cte_pkg::out_t want);
    int unsigned gap;
    escape_byte(it);
    if (typed) begin
      escaped_q.insert(escaped_q.size(), want);
    end else begin
      foreach (burst_q[i]) begin
        escaped_q.insert(escaped_q.size(), burst_q[i]);
      end
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    cte_pkg::in_t it;
    it.in_byte = b;
    it.in_last = ($urandom_range(0, 24) == 0);
    send_text_byte(it, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cte_pkg::cfg_idx_e idx,
                           input logic [cte_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      cte_pkg::CFG_TAG_LEN: tag_cfg.tag_len = data[4:0];
      cte_pkg::CFG_TAG_LO:  tag_cfg.tag[7:0] = data;
      cte_pkg::CFG_TAG_HI:  tag_cfg.tag[15:8] = data;
      default: ;
    endcase
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rx_left != 0) begin
      rx_left--;
    end else begin
      rx_left = pick_gap();
      if (rx_left != 0) begin
        out_stall_i <= 1'b1;
        rx_left--;
      end else begin
        out_stall_i <= 1'b0;
        rx_left = $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk_i) begin
    cte_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (escaped_q.size() == 0) begin
        $error("unexpected item: out_byte %h run_end %b text_end %b",
               out_data_o.out_byte, out_data_o.run_end, out_data_o.text_end);
        n_fail++;
      end else begin
        want = escaped_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, out_data_o.out_byte);
          n_fail++;
        end
        if (out_data_o.run_end !== want.run_end) begin
          $error("run_end: expected %b, got %b", want.run_end, out_data_o.run_end);
          n_fail++;
        end
        if (out_data_o.text_end !== want.text_end) begin
          $error("text_end: expected %b, got %b", want.text_end, out_data_o.text_end);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL closing_tag_escaper");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim
    int unsigned                    target;
    int unsigned                    phase_no;
    int unsigned                    burst_end;
    int unsigned                    eff;
    int unsigned                    k;
    int unsigned                    r;
    logic [4:0]                     len5;
    logic [cte_pkg::CFG_DATA_W-1:0] len_word;
    logic [15:0][7:0]               tagv;
    logic [7:0]                     b;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    n_sent      = 0;
    n_fail      = 0;
    idle_cycles = 0;
    rx_left     = 0;
    calm        = 1'b0;
    tag_cfg     = '0;
    cur_phase   = cte_pkg::PH_IDLE;
    match_cnt   = 0;
    foreach (held_bytes[i]) held_bytes[i] = '0;

    add_typed(8'h00, 1'b0, '{8'h00, 1'b1, 1'b0});
    add_typed(cte_pkg::CH_LT, 1'b0, '{cte_pkg::CH_LT, 1'b1, 1'b0});
    add_typed(8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1});
    add_cfg(cte_pkg::CFG_TAG_LO, 64'h0000_7470_6972_6373);
    add_cfg(cte_pkg::CFG_TAG_HI, 64'h3C5A_615F_2F3C_7A41);
    add_cfg(cte_pkg::CFG_TAG_LEN, 64'd6);
    add_text("</ScRipT", 1'b0);
    add_text("<</x", 1'b0);
    add_text("</S</", 1'b1);
    add_typed(cte_pkg::CH_LT, 1'b1, '{cte_pkg::CH_LT, 1'b1, 1'b1});
    // length lowered while a match is pending
    add_text("</sc", 1'b0);
    add_cfg(cte_pkg::CFG_TAG_LEN, 64'd2);
    add_text("q", 1'b0);
    // length zero while a '<' is pending
    add_text("<", 1'b0);
    add_cfg(cte_pkg::CFG_TAG_LEN, 64'd0);
    add_text("a", 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_text_byte(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    target   = n_sent + RandomItems;
    phase_no = 0;
    while (n_sent < target) begin
      settle();
      case (phase_no)
        0: len5 = 5'd16;
        1: len5 = 5'd31;
        2: len5 = 5'd0;
        3: len5 = 5'd1;
        default: begin
          r = $urandom_range(0, 9);
          if (r == 0) len5 = 5'd0;
          else if (r == 1) len5 = 5'd16;
          else if (r == 2) len5 = 5'($urandom_range(17, 31));
          else len5 = 5'($urandom_range(1, 8));
        end
      endcase
      for (int j = 0; j < 16; j++) begin
        r = $urandom_range(0, 19);
        if (r < 16) begin
          tagv[j] = 8'h61 + 8'($urandom_range(0, 25));
          if ($urandom_range(0, 1) == 1) tagv[j] = tagv[j] ^ cte_pkg::CASE_BIT;
        end else if (r < 18) begin
          tagv[j] = cte_pkg::CH_LT;
        end else begin
          tagv[j] = 8'($urandom_range(0, 255));
        end
      end
      len_word      = {$urandom(), $urandom()};
      len_word[4:0] = len5;
      write_reg(cte_pkg::CFG_TAG_LO, tagv[7:0]);
      write_reg(cte_pkg::CFG_TAG_HI, tagv[15:8]);
      write_reg(cte_pkg::CFG_TAG_LEN, len_word);
      calm      = ($urandom_range(0, 4) == 0);
      eff       = (len5 > TagMax) ? TagMax : len5;
      burst_end = n_sent + $urandom_range(20, 40);
      while (n_sent < burst_end && n_sent < target) begin
        if ($urandom_range(0, 9) < 7) begin
          feed_byte(cte_pkg::CH_LT);
          feed_byte(cte_pkg::CH_SLASH);
          k = ($urandom_range(0, 1) == 1) ? eff : $urandom_range(0, eff);
          for (int j = 0; j < k; j++) begin
            b = tagv[j];
            if ((b | cte_pkg::CASE_BIT) >= 8'h61 && (b | cte_pkg::CASE_BIT) <= 8'h7A &&
                $urandom_range(0, 1) == 1) begin
              b = b ^ cte_pkg::CASE_BIT;
            end
            feed_byte(b);
          end
          if ($urandom_range(0, 2) == 0) feed_byte(8'($urandom_range(0, 255)));
        end else begin
          r = $urandom_range(0, 19);
          if (r < 3) feed_byte(cte_pkg::CH_LT);
          else if (r < 6) feed_byte(cte_pkg::CH_SLASH);
          else feed_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 39) == 0) settle();
      end
      phase_no++;
    end

    calm = 1'b0;
    settle();
    if (n_fail == 0) begin
      $display("PASS closing_tag_escaper");
    end else begin
      $display("FAIL closing_tag_escaper");
    end
    $finish;
  end

endmodule
